// File: sv/pidaw_pkg.sv
// Shared types and constants of the PID controller with integral clamp.
package pidaw_pkg;

    // Width of the time step field, unsigned Q0.16 seconds
    localparam int TSTEP_W = 16;

    // Reset magnitudes of the drive and integral limits
    localparam longint OUT_LIMIT_RST = 64'sd16711680;
    localparam longint INT_LIMIT_RST = 64'sd6553600;

    typedef enum logic [0:0] {
        OP_COMPUTE = 1'b0,
        OP_CLEAR   = 1'b1
    } t_operation;

    typedef enum logic [2:0] {
        REG_KP     = 3'd0,
        REG_KI     = 3'd1,
        REG_KD     = 3'd2,
        REG_OLIM_LO = 3'd3,
        REG_OLIM_HI = 3'd4,
        REG_ILIM_LO = 3'd5,
        REG_ILIM_HI = 3'd6
    } t_reg_idx;

    // Start request to a serial arithmetic unit
    typedef struct packed {
        logic start;
        logic neg;
    } t_op_ctl;

endpackage

// File: sv/pidaw_mul.sv
// Serial shift-add multiplier on magnitudes, one multiplier bit per cycle, signed result.
module pidaw_mul #(
    parameter int AW = 33,
    parameter int BW = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pidaw_pkg::t_op_ctl      i_ctl,
    input  logic [AW-1:0]           i_a,
    input  logic [BW-1:0]           i_b,
    output logic                    o_done,
    output logic signed [AW+BW:0]   o_prod
);

    localparam int MW = AW + BW;
    localparam int PW = MW + 1;

    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_FIX
    } t_state;

    t_state              r_state;
    logic                r_done;
    logic                r_neg;
    logic [MW-1:0]       r_a;
    logic [BW-1:0]       r_b;
    logic [MW-1:0]       r_acc;
    logic signed [PW-1:0] r_prod;
    logic [PW-1:0]       w_acc_ext;

    assign w_acc_ext = {1'b0, r_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_ctl.start) begin
                        r_a     <= MW'(i_a);
                        r_b     <= i_b;
                        r_acc   <= '0;
                        r_neg   <= i_ctl.neg;
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    // stop as soon as no multiplier bits remain
                    if (r_b == '0) begin
                        r_state <= M_FIX;
                    end else begin
                        if (r_b[0]) begin
                            r_acc <= r_acc + r_a;
                        end
                        r_a <= {r_a[MW-2:0], 1'b0};
                        r_b <= {1'b0, r_b[BW-1:1]};
                    end
                end
                M_FIX: begin
                    r_prod  <= r_neg ? -w_acc_ext : w_acc_ext;
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// File: sv/pidaw_div.sv
// Restoring divider by the time step, one quotient bit per cycle, saturated signed result.
module pidaw_div #(
    parameter int NW = 48,
    parameter int OW = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pidaw_pkg::t_op_ctl                i_ctl,
    input  logic [NW-1:0]                     i_num,
    input  logic [pidaw_pkg::TSTEP_W-1:0]     i_den,
    output logic                              o_done,
    output logic signed [OW-1:0]              o_quot
);

    localparam int DW = pidaw_pkg::TSTEP_W;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW-1:0] QMAX     = NW'((64'd1 << (OW - 1)) - 64'd1);
    localparam logic [NW-1:0] QMIN_MAG = NW'(64'd1 << (OW - 1));
    localparam logic [CW-1:0] CNT_LOAD = CW'(NW);
    localparam logic [CW-1:0] CNT_LAST = CW'(1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIX
    } t_state;

    t_state               r_state;
    logic                 r_done;
    logic                 r_neg;
    logic [NW-1:0]        r_q;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_den;
    logic [CW-1:0]        r_cnt;
    logic signed [OW-1:0] r_quot;
    logic [DW:0]          w_trial;
    logic [DW:0]          w_sub;
    logic                 w_ge;

    assign w_trial = {r_rem, r_q[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_ctl.start) begin
                        r_q     <= i_num;
                        r_rem   <= '0;
                        r_den   <= i_den;
                        r_neg   <= i_ctl.neg;
                        r_cnt   <= CNT_LOAD;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    // shift the next dividend bit into the remainder, the quotient bit in at the bottom
                    r_rem <= w_ge ? w_sub[DW-1:0] : w_trial[DW-1:0];
                    r_q   <= {r_q[NW-2:0], w_ge};
                    r_cnt <= r_cnt - CNT_LAST;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    if (!r_neg) begin
                        r_quot <= (r_q > QMAX) ? QMAX[OW-1:0] : r_q[OW-1:0];
                    end else begin
                        r_quot <= (r_q > QMIN_MAG) ? QMIN_MAG[OW-1:0] : -r_q[OW-1:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: sv/pid_controller_antiwindup.sv
// Top level of the PID controller: sequencer, state, configuration registers and result register.
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_stall     i_operation, i_target_value,
//                                                    i_measured_value, i_time_step
//   result    out        o_out_valid / i_out_stall   o_drive_value
//   config    in         APB psel/penable/pwrite     paddr, pwdata, prdata
//
// A compute word runs the shared shift-add multiplier, which handles one multiplier bit a cycle,
// up to the highest set bit, for error*dt and the three gain products; the derivative divider
// runs alongside. A clear word or a zero time step goes from acceptance straight to S_DONE,
// which loads the result register once it is free.
// Reset is synchronous, loads the reset gains and limits, and clears state and result valid.
// A waiting result holds in its register under stall while the next word is taken in.
module pid_controller_antiwindup #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_operation,
    input  logic signed [VALUE_WIDTH-1:0]         i_target_value,
    input  logic signed [VALUE_WIDTH-1:0]         i_measured_value,
    input  logic [pidaw_pkg::TSTEP_W-1:0]         i_time_step,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [VALUE_WIDTH-1:0]         o_drive_value,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [((VALUE_WIDTH > 32) ? 6 : 5)-1:0] paddr,
    input  logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                                  pready
);

    localparam int W   = VALUE_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int EW  = W + 1;
    localparam int AW  = W + 1;
    localparam int BW  = W;
    localparam int PW  = AW + BW + 1;
    localparam int SW  = 2 * W + 4;
    localparam int NW  = EW + F;
    localparam int PDW = (W > 32) ? 64 : 32;
    localparam int PAW = (W > 32) ? 6 : 5;
    localparam int ASH = (W > 32) ? 3 : 2;

    localparam logic [W-1:0] OLIM_LO_RST = W'(-pidaw_pkg::OUT_LIMIT_RST);
    localparam logic [W-1:0] OLIM_HI_RST = W'(pidaw_pkg::OUT_LIMIT_RST);
    localparam logic [W-1:0] ILIM_LO_RST = W'(-pidaw_pkg::INT_LIMIT_RST);
    localparam logic [W-1:0] ILIM_HI_RST = W'(pidaw_pkg::INT_LIMIT_RST);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL_ERR,
        S_INT_CLAMP,
        S_KP_GO,
        S_MUL_KP,
        S_KI_GO,
        S_MUL_KI,
        S_KD_GO,
        S_MUL_KD,
        S_OUT_CLAMP,
        S_DONE
    } t_state;

    // configuration
    logic signed [W-1:0] r_kp, r_ki, r_kd;
    logic signed [W-1:0] r_olim_lo, r_olim_hi, r_ilim_lo, r_ilim_hi;
    pidaw_pkg::t_reg_idx w_idx;
    logic                w_wr;

    // sequencer and datapath
    t_state                       r_state;
    logic signed [W-1:0]          r_integ;
    logic signed [W-1:0]          r_last;
    logic signed [EW-1:0]         r_err;
    logic signed [EW-1:0]         r_diff;
    logic [pidaw_pkg::TSTEP_W-1:0] r_dt;
    logic signed [W-1:0]          r_deriv;
    logic                         r_dvalid;
    logic signed [SW-1:0]         r_acc;
    logic signed [W-1:0]          r_res;
    logic                         r_out_valid;
    logic signed [W-1:0]          r_drive;

    logic                         w_accept;
    logic signed [EW-1:0]         w_a_src;
    logic [EW-1:0]                w_a_mag;
    logic signed [W-1:0]          w_gain;
    logic [W-1:0]                 w_g_mag;
    logic                         w_gain_sel;
    logic [BW-1:0]                w_b_mag;
    pidaw_pkg::t_op_ctl           w_mul_ctl;
    pidaw_pkg::t_op_ctl           w_div_ctl;
    logic [EW-1:0]                w_diff_mag;
    logic [NW-1:0]                w_num;
    logic                         w_mul_done;
    logic signed [PW-1:0]         w_prod;
    logic signed [SW-1:0]         w_term;
    logic                         w_div_done;
    logic signed [W-1:0]          w_quot;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_idx  = pidaw_pkg::t_reg_idx'(paddr[PAW-1:ASH]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= '0;
            r_ki      <= '0;
            r_kd      <= '0;
            r_olim_lo <= OLIM_LO_RST;
            r_olim_hi <= OLIM_HI_RST;
            r_ilim_lo <= ILIM_LO_RST;
            r_ilim_hi <= ILIM_HI_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                pidaw_pkg::REG_KP:      r_kp      <= pwdata[W-1:0];
                pidaw_pkg::REG_KI:      r_ki      <= pwdata[W-1:0];
                pidaw_pkg::REG_KD:      r_kd      <= pwdata[W-1:0];
                pidaw_pkg::REG_OLIM_LO: r_olim_lo <= pwdata[W-1:0];
                pidaw_pkg::REG_OLIM_HI: r_olim_hi <= pwdata[W-1:0];
                pidaw_pkg::REG_ILIM_LO: r_ilim_lo <= pwdata[W-1:0];
                pidaw_pkg::REG_ILIM_HI: r_ilim_hi <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            pidaw_pkg::REG_KP:      prdata = PDW'(unsigned'(r_kp));
            pidaw_pkg::REG_KI:      prdata = PDW'(unsigned'(r_ki));
            pidaw_pkg::REG_KD:      prdata = PDW'(unsigned'(r_kd));
            pidaw_pkg::REG_OLIM_LO: prdata = PDW'(unsigned'(r_olim_lo));
            pidaw_pkg::REG_OLIM_HI: prdata = PDW'(unsigned'(r_olim_hi));
            pidaw_pkg::REG_ILIM_LO: prdata = PDW'(unsigned'(r_ilim_lo));
            pidaw_pkg::REG_ILIM_HI: prdata = PDW'(unsigned'(r_ilim_hi));
            default:                prdata = '0;
        endcase
    end

    // ---------------- operand selection ----------------
    always_comb begin
        w_a_src       = r_err;
        w_gain        = r_kp;
        w_gain_sel    = 1'b1;
        w_mul_ctl     = '0;
        unique case (r_state)
            S_PREP: begin
                w_gain_sel      = 1'b0;
                w_mul_ctl.start = 1'b1;
            end
            S_KP_GO: begin
                w_mul_ctl.start = 1'b1;
            end
            S_KI_GO: begin
                w_a_src         = EW'(r_integ);
                w_gain          = r_ki;
                w_mul_ctl.start = 1'b1;
            end
            S_KD_GO: begin
                w_a_src         = EW'(r_deriv);
                w_gain          = r_kd;
                // hold until the derivative is in
                w_mul_ctl.start = r_dvalid;
            end
            default: ;
        endcase
        w_mul_ctl.neg = w_a_src[EW-1] ^ (w_gain_sel & w_gain[W-1]);
    end

    assign w_a_mag = w_a_src[EW-1] ? -w_a_src : w_a_src;
    assign w_g_mag = w_gain[W-1] ? -w_gain : w_gain;
    assign w_b_mag = w_gain_sel ? w_g_mag : BW'(r_dt);

    assign w_diff_mag    = r_diff[EW-1] ? -r_diff : r_diff;
    assign w_num         = {w_diff_mag, {F{1'b0}}};
    assign w_div_ctl.start = (r_state == S_PREP);
    assign w_div_ctl.neg   = r_diff[EW-1];

    // floor of a product by the fraction scale, widened for summing
    assign w_term = SW'(w_prod >>> F);

    pidaw_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mul_ctl),
        .i_a     (w_a_mag),
        .i_b     (w_b_mag),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pidaw_div #(
        .NW (NW),
        .OW (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_num),
        .i_den   (r_dt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ---------------- sequencer ----------------
    assign w_accept   = i_in_valid & (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integ     <= '0;
            r_last      <= '0;
            r_dvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_div_done) begin
                r_deriv  <= w_quot;
                r_dvalid <= 1'b1;
            end
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_operation == pidaw_pkg::OP_CLEAR) begin
                            r_integ <= '0;
                            r_last  <= '0;
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else if (i_time_step == '0) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_err   <= EW'(i_target_value) - EW'(i_measured_value);
                            r_diff  <= EW'(r_last) - EW'(i_measured_value);
                            r_last  <= i_measured_value;
                            r_dt    <= i_time_step;
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_dvalid <= 1'b0;
                    r_state  <= S_MUL_ERR;
                end
                S_MUL_ERR: begin
                    if (w_mul_done) begin
                        r_acc   <= SW'(r_integ) + w_term;
                        r_state <= S_INT_CLAMP;
                    end
                end
                S_INT_CLAMP: begin
                    // upper limit takes precedence when the limits cross
                    if (r_acc > SW'(r_ilim_hi)) begin
                        r_integ <= r_ilim_hi;
                    end else if (r_acc < SW'(r_ilim_lo)) begin
                        r_integ <= r_ilim_lo;
                    end else begin
                        r_integ <= r_acc[W-1:0];
                    end
                    r_state <= S_KP_GO;
                end
                S_KP_GO: r_state <= S_MUL_KP;
                S_MUL_KP: begin
                    if (w_mul_done) begin
                        r_acc   <= w_term;
                        r_state <= S_KI_GO;
                    end
                end
                S_KI_GO: r_state <= S_MUL_KI;
                S_MUL_KI: begin
                    if (w_mul_done) begin
                        r_acc   <= r_acc + w_term;
                        r_state <= S_KD_GO;
                    end
                end
                S_KD_GO: begin
                    if (r_dvalid) begin
                        r_state <= S_MUL_KD;
                    end
                end
                S_MUL_KD: begin
                    if (w_mul_done) begin
                        r_acc   <= r_acc + w_term;
                        r_state <= S_OUT_CLAMP;
                    end
                end
                S_OUT_CLAMP: begin
                    if (r_acc > SW'(r_olim_hi)) begin
                        r_res <= r_olim_hi;
                    end else if (r_acc < SW'(r_olim_lo)) begin
                        r_res <= r_olim_lo;
                    end else begin
                        r_res <= r_acc[W-1:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // load the result word once the register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_drive     <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_value = r_drive;

endmodule

// File: sv/pidaw_checker.sv
// Port-level checker of the PID controller, bound to the top level.
module pidaw_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               i_operation,
    input logic [pidaw_pkg::TSTEP_W-1:0]      i_time_step,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [VALUE_WIDTH-1:0]             o_drive_value
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_zero_word;
    logic [1:0] r_cnt;
    logic       r_zero;

    assign w_in_acc    = i_in_valid & !o_in_stall;
    assign w_out_acc   = o_out_valid & !i_out_stall;
    assign w_zero_word = (i_operation == pidaw_pkg::OP_CLEAR) || (i_time_step == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_zero <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_in_acc} - {1'b0, w_out_acc};
            // track only words whose result is the next one shown
            if (w_in_acc && w_zero_word &&
                (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_out_acc))) begin
                r_zero <= 1'b1;
            end else if (w_out_acc) begin
                r_zero <= 1'b0;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive_value))
        else $error("result word changed under stall");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("second word taken while one is at work");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> r_cnt != 2'd0)
        else $error("result word without an input word");

    a_two_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> o_in_stall)
        else $error("input open with two words outstanding");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zero && o_out_valid |-> o_drive_value == '0)
        else $error("clear or zero step gave a nonzero drive");

endmodule

bind pid_controller_antiwindup pidaw_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_pidaw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_operation   (i_operation),
    .i_time_step   (i_time_step),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_drive_value (o_drive_value)
);
